FILE: hdl/fmt_pkg.sv
// fmt_pkg: shared types, register codes and constants of the fm modulator
// with tone injection. No dependencies; the interfaces and queue omit it.
package fmt_pkg;

  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 31;
  localparam int LEVEL_W     = 15;
  localparam int STEP_W      = 31;
  localparam int Q30_FRAC    = 30;
  localparam int Q30_W       = 32;
  localparam int KIND_W      = 2;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [LEVEL_W-1:0] SCALE_RESET = 15'h7fff;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_ENABLE      = 3'd0,
    REG_TONE_ENABLE = 3'd1,
    REG_TONE_LEVEL  = 3'd2,
    REG_TONE_SCALE  = 3'd3,
    REG_TONE_STEP   = 3'd4,
    REG_DEV_STEP    = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic               enable;
    logic               tone_enable;
    logic [LEVEL_W-1:0] tone_level;
    logic [LEVEL_W-1:0] tone_scale;
    logic [STEP_W-1:0]  tone_step;
    logic [STEP_W-1:0]  dev_step;
  } cfg_t;

  typedef enum logic {
    OP_PROCESS = 1'b0,
    OP_CLEAR   = 1'b1
  } op_t;

  // work class of a queued item, decided at the front
  typedef enum logic [KIND_W-1:0] {
    KIND_CLEAR,
    KIND_BYPASS,
    KIND_MOD,
    KIND_MOD_TONE
  } kind_t;

  typedef enum logic [1:0] {
    SN_IDLE,
    SN_MUL,
    SN_ACC
  } sn_state_t;

  // sine unit step numbers
  localparam logic [2:0] STEP_T2        = 3'd0;
  localparam logic [2:0] STEP_POLY_LAST = 3'd4;
  localparam logic [2:0] STEP_SIN       = 3'd5;
  localparam logic [2:0] SIN_COEF_TOP   = 3'd4;

  typedef enum logic [4:0] {
    BK_IDLE,
    BK_BYPASS,
    BK_TONE_ADV,
    BK_TCOS_GO,
    BK_TCOS_WAIT,
    BK_TERM_MUL,
    BK_SUM,
    BK_SCALE_MUL,
    BK_SAT,
    BK_INC_MUL,
    BK_PHASE,
    BK_MCOS_GO,
    BK_MCOS_WAIT,
    BK_OI_MUL,
    BK_MSIN_GO,
    BK_MSIN_WAIT,
    BK_OQ_MUL,
    BK_EMIT
  } bk_state_t;

  // odd polynomial for sin(pi/2*t), Q30
  function automatic logic signed [Q30_W-1:0] sin_coef(input logic [2:0] k);
    case (k)
      3'd0:    return 32'sd1686629713;
      3'd1:    return -32'sd693598668;
      3'd2:    return 32'sd85569305;
      3'd3:    return -32'sd5026995;
      3'd4:    return 32'sd172271;
      default: return '0;
    endcase
  endfunction

endpackage

FILE: hdl/fmt_in_if.sv
// fmt_in_if: sample input channel, valid/ready with operation and I/Q.
// No dependencies.
interface fmt_in_if #(parameter int SAMPLE_BITS = 16);
  logic                          valid;
  logic                          ready;
  logic                          operation;
  logic signed [SAMPLE_BITS-1:0] in_i;
  logic signed [SAMPLE_BITS-1:0] in_q;

  modport source(output valid, operation, in_i, in_q, input ready);
  modport sink(input valid, operation, in_i, in_q, output ready);
endinterface

FILE: hdl/fmt_out_if.sv
// fmt_out_if: baseband output channel, valid/ready with I/Q.
// No dependencies.
interface fmt_out_if #(parameter int SAMPLE_BITS = 16);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] out_i;
  logic signed [SAMPLE_BITS-1:0] out_q;

  modport source(output valid, out_i, out_q, input ready);
  modport sink(input valid, out_i, out_q, output ready);
endinterface

FILE: hdl/fmt_front.sv
// fmt_front: configuration registers and input classification.
// Depends on fmt_pkg and fmt_in_if; feeds fmt_queue.
module fmt_front #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  fmt_in_if.sink                            in_ch,
  input  logic                              cfg_we,
  input  logic [fmt_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [fmt_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                              q_full,
  output logic                              push,
  output logic [fmt_pkg::KIND_W+2*SAMPLE_BITS-1:0] push_data,
  output fmt_pkg::cfg_t                     cfg
);
  import fmt_pkg::*;

  cfg_t  cfg_r, cfg_nxt;
  kind_t kind;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_addr)
        REG_ENABLE:      cfg_nxt.enable      = cfg_wdata[0];
        REG_TONE_ENABLE: cfg_nxt.tone_enable = cfg_wdata[0];
        REG_TONE_LEVEL:  cfg_nxt.tone_level  = cfg_wdata[LEVEL_W-1:0];
        REG_TONE_SCALE:  cfg_nxt.tone_scale  = cfg_wdata[LEVEL_W-1:0];
        REG_TONE_STEP:   cfg_nxt.tone_step   = cfg_wdata[STEP_W-1:0];
        REG_DEV_STEP:    cfg_nxt.dev_step    = cfg_wdata[STEP_W-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable      <= 1'b0;
      cfg_r.tone_enable <= 1'b0;
      cfg_r.tone_level  <= '0;
      cfg_r.tone_scale  <= SCALE_RESET;
      cfg_r.tone_step   <= '0;
      cfg_r.dev_step    <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // user must change config only while idle (not enforced here); classifying relies on it
  always_comb begin
    if (op_t'(in_ch.operation) == OP_CLEAR) begin
      kind = KIND_CLEAR;
    end else if (!cfg_r.enable) begin
      kind = KIND_BYPASS;
    end else if (cfg_r.tone_enable) begin
      kind = KIND_MOD_TONE;
    end else begin
      kind = KIND_MOD;
    end
  end

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;
  assign push_data   = {kind, in_ch.in_i, in_ch.in_q};
  assign cfg         = cfg_r;

endmodule

FILE: hdl/fmt_queue.sv
// fmt_queue: small flop-based fifo between front and back, show-ahead read.
// Depends on nothing but its parameters.
module fmt_queue #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r, wr_ptr_nxt, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: hdl/fmt_sine.sv
// fmt_sine: iterative Q30 sine from a quadrant-folded table index, one shared
// 32x31 multiplier, Horner steps in SN_MUL/SN_ACC pairs. Depends on fmt_pkg.
module fmt_sine #(
  parameter int SINE_ADDR_BITS = 10
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [SINE_ADDR_BITS-1:0]        idx,
  output logic                             done,
  output logic signed [fmt_pkg::Q30_W-1:0] result
);
  import fmt_pkg::*;

  localparam int SAB = SINE_ADDR_BITS;
  localparam int QB  = SAB - 2;
  localparam int T_W = Q30_FRAC + 1;
  localparam int MW  = 2 * Q30_W - 2;
  localparam logic signed [Q30_W:0] ONE_Q30 = (Q30_W + 1)'(64'sd1 <<< Q30_FRAC);

  sn_state_t state_r, state_nxt;
  logic [2:0]       step_r, coef_idx;
  logic [1:0]       quad_r;
  logic [T_W-1:0]   t_r, t2_r, b_r, t_in;
  logic [Q30_W-1:0] a_r, prod_r;
  logic             neg_r, done_r;
  logic signed [Q30_W-1:0] result_r, s_clamp;
  logic             load_start, finish;
  logic [QB:0]      r_fold;
  logic [MW-1:0]    mul_full;
  logic signed [Q30_W:0]   sprod_mag, sprod;
  logic signed [Q30_W+1:0] poly, poly_mag;

  // fold the second and fourth quadrants onto the first
  assign r_fold = idx[SAB-2] ? (QB + 1)'(1 << QB) - {1'b0, idx[QB-1:0]}
                             : {1'b0, idx[QB-1:0]};
  assign t_in   = T_W'(r_fold) << (Q30_FRAC - QB);

  assign mul_full  = MW'(a_r) * MW'(b_r);
  assign sprod_mag = $signed({1'b0, prod_r});
  assign sprod     = neg_r ? -sprod_mag : sprod_mag;
  assign coef_idx  = STEP_POLY_LAST - step_r;
  assign poly      = (Q30_W + 2)'(sin_coef(coef_idx)) + (Q30_W + 2)'(sprod);
  assign poly_mag  = poly[Q30_W+1] ? -poly : poly;

  always_comb begin
    if (sprod > ONE_Q30) begin
      s_clamp = Q30_W'(ONE_Q30);
    end else if (sprod < 0) begin
      s_clamp = '0;
    end else begin
      s_clamp = Q30_W'(sprod);
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      SN_IDLE: if (start) state_nxt = SN_MUL;
      SN_MUL:  state_nxt = SN_ACC;
      SN_ACC:  state_nxt = (step_r == STEP_SIN) ? SN_IDLE : SN_MUL;
      default: state_nxt = SN_IDLE;
    endcase
  end

  always_comb begin
    load_start = 1'b0;
    finish     = 1'b0;
    case (state_r)
      SN_IDLE: load_start = start;
      SN_ACC:  finish = (step_r == STEP_SIN);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SN_IDLE;
      step_r  <= STEP_T2;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= finish;
      if (load_start) begin
        step_r <= STEP_T2;
      end else if (state_r == SN_ACC) begin
        step_r <= step_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_start) begin
      quad_r <= idx[SAB-1 -: 2];
      t_r    <= t_in;
      a_r    <= Q30_W'(t_in);
      b_r    <= t_in;
      neg_r  <= 1'b0;
    end
    if (state_r == SN_MUL) begin
      prod_r <= mul_full[Q30_FRAC +: Q30_W];
    end
    if (state_r == SN_ACC) begin
      if (step_r == STEP_T2) begin
        t2_r  <= prod_r[T_W-1:0];
        a_r   <= Q30_W'(sin_coef(SIN_COEF_TOP));
        b_r   <= prod_r[T_W-1:0];
        neg_r <= 1'b0;
      end else begin
        a_r   <= poly_mag[Q30_W-1:0];
        neg_r <= poly[Q30_W+1];
        b_r   <= (step_r == STEP_POLY_LAST) ? t_r : t2_r;
      end
    end
    if (finish) begin
      result_r <= quad_r[1] ? -s_clamp : s_clamp;
    end
  end

  assign done   = done_r;
  assign result = result_r;

endmodule

FILE: hdl/fmt_back.sv
// fmt_back: executes queued items: phase accumulators, tone mix, deviation
// and the output register. Depends on fmt_pkg, fmt_out_if and fmt_sine.
module fmt_back #(
  parameter int PHASE_BITS     = 32,
  parameter int SINE_ADDR_BITS = 10,
  parameter int SAMPLE_BITS    = 16
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  fmt_pkg::cfg_t                           cfg,
  input  logic                                    q_empty,
  input  logic [fmt_pkg::KIND_W+2*SAMPLE_BITS-1:0] q_data,
  output logic                                    q_pop,
  fmt_out_if.source                               out_ch
);
  import fmt_pkg::*;

  localparam int SB   = SAMPLE_BITS;
  localparam int PB   = PHASE_BITS;
  localparam int SAB  = SINE_ADDR_BITS;
  localparam int QW   = KIND_W + 2 * SB;
  localparam int TPW  = LEVEL_W + 1 + Q30_W;
  localparam int TSH  = Q30_FRAC + LEVEL_W + 1 - SB;
  localparam int SUMW = SB + 2;
  localparam int SPW  = LEVEL_W + 1 + SUMW;
  localparam int IPW  = SB + STEP_W + 1;
  localparam int EXTW = IPW + PB;
  localparam int OPW  = SB + 1 + Q30_W;

  localparam logic [SB-1:0] AMP_K =
    SB'((64'd7071 * (64'd1 << (SB - 1)) + 64'd5000) / 64'd10000);
  localparam logic signed [TPW-1:0] TERM_HALF  = TPW'(64'sd1 <<< (TSH - 1));
  localparam logic signed [SPW-1:0] SCALE_HALF = SPW'(64'sd1 <<< (LEVEL_W - 1));
  localparam logic signed [OPW-1:0] OUT_HALF   = OPW'(64'sd1 <<< (Q30_FRAC - 1));
  localparam logic signed [SPW-1:0] SAT_HI = SPW'((64'sd1 <<< (SB - 1)) - 64'sd1);
  localparam logic signed [SPW-1:0] SAT_LO = SPW'(-(64'sd1 <<< (SB - 1)));
  localparam logic [SAB-1:0] QUARTER = SAB'(1) << (SAB - 2);

  bk_state_t state_r, state_nxt;
  kind_t                   head_kind;
  logic signed [SB-1:0]    head_i, head_q;
  logic signed [SB-1:0]    samp_i_r, samp_q_r, x_r, x_sat;
  logic [PB-1:0]           tone_phase_r, mod_phase_r;
  logic signed [TPW-1:0]   tprod_r, term_full;
  logic signed [SUMW-1:0]  sum_r, sum_nxt;
  logic signed [SPW-1:0]   sprod_r, scaled;
  logic signed [IPW-1:0]   iprod_r;
  logic signed [EXTW-1:0]  inc_ext;
  logic signed [OPW-1:0]   oprod_i_r, oprod_q_r, oi_full, oq_full;
  logic signed [SB-1:0]    out_i_r, out_q_r;
  logic                    out_valid_r, out_valid_nxt, slot_free, out_load;
  logic                    sn_start, sn_done;
  logic [SAB-1:0]          sn_idx, tone_idx, mod_idx;
  logic signed [Q30_W-1:0] sn_result;

  assign head_kind = kind_t'(q_data[QW-1 -: KIND_W]);
  assign head_i    = $signed(q_data[2*SB-1 -: SB]);
  assign head_q    = $signed(q_data[SB-1:0]);

  assign slot_free     = !out_valid_r || out_ch.ready;
  assign out_valid_nxt = out_load || (out_valid_r && !out_ch.ready);

  // arithmetic between the registered products
  assign term_full = (tprod_r + TERM_HALF) >>> TSH;
  assign sum_nxt   = SUMW'(samp_i_r) + SUMW'(term_full);
  assign scaled    = (sprod_r + SCALE_HALF) >>> LEVEL_W;
  assign inc_ext   = EXTW'(iprod_r) >>> (SB - 1);
  assign oi_full   = (oprod_i_r + OUT_HALF) >>> Q30_FRAC;
  assign oq_full   = (oprod_q_r + OUT_HALF) >>> Q30_FRAC;

  always_comb begin
    if (scaled > SAT_HI) begin
      x_sat = SB'(SAT_HI);
    end else if (scaled < SAT_LO) begin
      x_sat = SB'(SAT_LO);
    end else begin
      x_sat = SB'(scaled);
    end
  end

  assign tone_idx = tone_phase_r[PB-1 -: SAB];
  assign mod_idx  = mod_phase_r[PB-1 -: SAB];

  // cosine is the sine a quarter turn ahead
  always_comb begin
    case (state_r)
      BK_TCOS_GO: sn_idx = tone_idx + QUARTER;
      BK_MCOS_GO: sn_idx = mod_idx + QUARTER;
      default:    sn_idx = mod_idx;
    endcase
  end

  fmt_sine #(
    .SINE_ADDR_BITS(SAB)
  ) u_sine (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (sn_start),
    .idx    (sn_idx),
    .done   (sn_done),
    .result (sn_result)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          case (head_kind)
            KIND_BYPASS:   state_nxt = BK_BYPASS;
            KIND_MOD:      state_nxt = BK_INC_MUL;
            KIND_MOD_TONE: state_nxt = BK_TONE_ADV;
            default:       state_nxt = BK_IDLE;
          endcase
        end
      end
      BK_BYPASS:    if (slot_free) state_nxt = BK_IDLE;
      BK_TONE_ADV:  state_nxt = BK_TCOS_GO;
      BK_TCOS_GO:   state_nxt = BK_TCOS_WAIT;
      BK_TCOS_WAIT: if (sn_done) state_nxt = BK_TERM_MUL;
      BK_TERM_MUL:  state_nxt = BK_SUM;
      BK_SUM:       state_nxt = BK_SCALE_MUL;
      BK_SCALE_MUL: state_nxt = BK_SAT;
      BK_SAT:       state_nxt = BK_INC_MUL;
      BK_INC_MUL:   state_nxt = BK_PHASE;
      BK_PHASE:     state_nxt = BK_MCOS_GO;
      BK_MCOS_GO:   state_nxt = BK_MCOS_WAIT;
      BK_MCOS_WAIT: if (sn_done) state_nxt = BK_OI_MUL;
      BK_OI_MUL:    state_nxt = BK_MSIN_GO;
      BK_MSIN_GO:   state_nxt = BK_MSIN_WAIT;
      BK_MSIN_WAIT: if (sn_done) state_nxt = BK_OQ_MUL;
      BK_OQ_MUL:    state_nxt = BK_EMIT;
      BK_EMIT:      if (slot_free) state_nxt = BK_IDLE;
      default:      state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = 1'b0;
    sn_start = 1'b0;
    out_load = 1'b0;
    case (state_r)
      BK_IDLE:                            q_pop = !q_empty;
      BK_TCOS_GO, BK_MCOS_GO, BK_MSIN_GO: sn_start = 1'b1;
      BK_BYPASS, BK_EMIT:                 out_load = slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= BK_IDLE;
      out_valid_r  <= 1'b0;
      tone_phase_r <= '0;
      mod_phase_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (q_pop && head_kind == KIND_CLEAR) begin
        tone_phase_r <= '0;
        mod_phase_r  <= '0;
      end
      if (state_r == BK_TONE_ADV) begin
        tone_phase_r <= tone_phase_r + PB'(cfg.tone_step);
      end
      if (state_r == BK_PHASE) begin
        mod_phase_r <= mod_phase_r + inc_ext[PB-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      samp_i_r <= head_i;
      samp_q_r <= head_q;
      x_r      <= head_i;
    end
    case (state_r)
      BK_TERM_MUL:  tprod_r   <= $signed({1'b0, cfg.tone_level}) * sn_result;
      BK_SUM:       sum_r     <= sum_nxt;
      BK_SCALE_MUL: sprod_r   <= $signed({1'b0, cfg.tone_scale}) * sum_r;
      BK_SAT:       x_r       <= x_sat;
      BK_INC_MUL:   iprod_r   <= x_r * $signed({1'b0, cfg.dev_step});
      BK_OI_MUL:    oprod_i_r <= $signed({1'b0, AMP_K}) * sn_result;
      BK_OQ_MUL:    oprod_q_r <= $signed({1'b0, AMP_K}) * sn_result;
      default: ;
    endcase
    if (out_load) begin
      if (state_r == BK_BYPASS) begin
        out_i_r <= samp_i_r;
        out_q_r <= samp_q_r;
      end else begin
        out_i_r <= SB'(oi_full);
        out_q_r <= SB'(oq_full);
      end
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.out_i = out_i_r;
  assign out_ch.out_q = out_q_r;

endmodule

FILE: hdl/fm_modulator_with_tone.sv
// fm_modulator_with_tone: top level, wires front, queue and back together.
// Depends on fmt_pkg, fmt_in_if, fmt_out_if, fmt_front, fmt_queue, fmt_back.
//
// One audio sample in, one complex FM baseband sample out. The front takes a
// transfer each cycle while its four-entry queue has room, so the input side
// keeps moving while the back works or the output waits. In the back a clear
// is done as it is popped in BK_IDLE, a bypass sample goes through BK_BYPASS,
// and a modulated sample runs the tone states if tone injection is on, then
// the phase and sine states. Each sine or cosine is a degree-9 polynomial run
// through one shared multiplier in six multiply/accumulate steps, each an
// SN_MUL/SN_ACC pair; a modulated sample needs two (three with the tone).
// Registers may be written only while the block is idle; they never touch the
// phases, so software issues a clear item after changing the setup.
module fm_modulator_with_tone #(
  parameter int PHASE_BITS     = 32,
  parameter int SINE_ADDR_BITS = 10,
  parameter int SAMPLE_BITS    = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  fmt_in_if.sink                         in_ch,
  fmt_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [fmt_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [fmt_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import fmt_pkg::*;

  localparam int QW = KIND_W + 2 * SAMPLE_BITS;

  cfg_t          cfg;
  logic          push, pop, q_full, q_empty;
  logic [QW-1:0] push_data, q_data;

  fmt_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data),
    .cfg       (cfg)
  );

  fmt_queue #(
    .WIDTH(QW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .rd_data   (q_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  fmt_back #(
    .PHASE_BITS     (PHASE_BITS),
    .SINE_ADDR_BITS (SINE_ADDR_BITS),
    .SAMPLE_BITS    (SAMPLE_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .q_empty (q_empty),
    .q_data  (q_data),
    .q_pop   (pop),
    .out_ch  (out_ch)
  );

endmodule

FILE: tb/tb_top.sv
// tb_top: self-checking bench for fm_modulator_with_tone. Drives samples and
// register writes, predicts every baseband transfer and compares it in order.
// Depends on fmt_pkg, fmt_in_if, fmt_out_if and the block under hdl/.
module tb_top;
  import fmt_pkg::*;

  localparam int SAMPLE_W       = 16;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 80;
  localparam int LONG_HOLD      = 300;
  localparam int SWEEP_PHASES   = 18;
  localparam int SWEEP_ITEMS    = 50;

  localparam longint AMP_K    = 23170;
  localparam longint Q30_ONE  = 64'sd1 <<< 30;
  localparam longint HALF_Q30 = 64'sd1 <<< 29;
  localparam longint HALF_Q15 = 64'sd1 <<< 14;

  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_7 = 3'd7;

  localparam logic signed [SAMPLE_W-1:0] S_MAX = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] S_MIN = 16'sh8000;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] re;
    logic signed [SAMPLE_W-1:0] im;
  } baseband_t;

  typedef enum logic [1:0] {
    RX_STEADY,
    RX_PATTERN,
    RX_SPARSE
  } rx_mode_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  fmt_in_if  #(.SAMPLE_BITS(SAMPLE_W)) in_ch ();
  fmt_out_if #(.SAMPLE_BITS(SAMPLE_W)) out_ch ();

  fm_modulator_with_tone #(
    .PHASE_BITS    (32),
    .SINE_ADDR_BITS(10),
    .SAMPLE_BITS   (SAMPLE_W)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  // shadow of the block: registers and both phase accumulators
  cfg_t        shadow_cfg;
  logic [31:0] tone_phase_acc;
  logic [31:0] mod_phase_acc;
  baseband_t   pending_baseband[$];

  int       n_errors    = 0;
  int       idle_cycles = 0;
  int       burst_left  = 0;
  int       hold_left   = 0;
  bit       tx_bursty   = 1'b0;
  rx_mode_t rx_mode     = RX_STEADY;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic longint poly_coef(input int k);
    case (k)
      0:       return 64'sd1686629713;
      1:       return -64'sd693598668;
      2:       return 64'sd85569305;
      3:       return -64'sd5026995;
      default: return 64'sd172271;
    endcase
  endfunction

  // magnitude product truncated toward zero, Q30
  function automatic longint mul_q30_trunc(input longint a, input longint b);
    longint ua, ub, m;
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    m  = (ua * ub) >>> 30;
    return ((a < 0) != (b < 0)) ? -m : m;
  endfunction

  function automatic longint sin_q30(input logic [31:0] ph);
    logic [9:0] idx;
    longint     r, t, t2, acc, s;
    int         k;
    idx = ph[31:22];
    r   = idx[7:0];
    // odd quadrants run the quarter wave backwards
    if (idx[8]) r = 256 - r;
    t   = r <<< 22;
    t2  = mul_q30_trunc(t, t);
    acc = poly_coef(4);
    for (k = 3; k >= 0; k--) acc = poly_coef(k) + mul_q30_trunc(acc, t2);
    s = mul_q30_trunc(acc, t);
    if (s > Q30_ONE) s = Q30_ONE;
    if (s < 0) s = 0;
    return idx[9] ? -s : s;
  endfunction

  function automatic longint cos_q30(input logic [31:0] ph);
    return sin_q30(ph + 32'h4000_0000);
  endfunction

  // advances the shadow state; returns 1 when the item yields a transfer
  function automatic bit predict_baseband(input op_t op,
                                          input logic signed [SAMPLE_W-1:0] a_i,
                                          input logic signed [SAMPLE_W-1:0] a_q,
                                          output baseband_t res);
    longint x, term, lvl, scl, dev, inc, re, im;
    res = '0;
    if (op == OP_CLEAR) begin
      tone_phase_acc = '0;
      mod_phase_acc  = '0;
      return 1'b0;
    end
    if (!shadow_cfg.enable) begin
      res.re = a_i;
      res.im = a_q;
      return 1'b1;
    end
    x = a_i;
    if (shadow_cfg.tone_enable) begin
      tone_phase_acc = tone_phase_acc + {1'b0, shadow_cfg.tone_step};
      lvl  = shadow_cfg.tone_level;
      scl  = shadow_cfg.tone_scale;
      term = (lvl * cos_q30(tone_phase_acc) + HALF_Q30) >>> 30;
      x    = (scl * (x + term) + HALF_Q15) >>> 15;
      if (x > 32767) x = 32767;
      if (x < -32768) x = -32768;
    end
    dev = shadow_cfg.dev_step;
    inc = (x * dev) >>> 15;
    mod_phase_acc = mod_phase_acc + inc[31:0];
    re = (AMP_K * cos_q30(mod_phase_acc) + HALF_Q30) >>> 30;
    im = (AMP_K * sin_q30(mod_phase_acc) + HALF_Q30) >>> 30;
    res.re = re[SAMPLE_W-1:0];
    res.im = im[SAMPLE_W-1:0];
    return 1'b1;
  endfunction

  function automatic logic [LEVEL_W-1:0] pick_q15();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return '1;
      default: return LEVEL_W'($urandom);
    endcase
  endfunction

  function automatic logic [STEP_W-1:0] pick_step();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return STEP_W'($urandom_range(0, 1 << 20));
      default: return STEP_W'($urandom);
    endcase
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return S_MIN;
      1:       return S_MAX;
      2:       return SAMPLE_W'(int'($urandom_range(0, 512)) - 256);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_ENABLE:      shadow_cfg.enable      = val[0];
      REG_TONE_ENABLE: shadow_cfg.tone_enable = val[0];
      REG_TONE_LEVEL:  shadow_cfg.tone_level  = val[LEVEL_W-1:0];
      REG_TONE_SCALE:  shadow_cfg.tone_scale  = val[LEVEL_W-1:0];
      REG_TONE_STEP:   shadow_cfg.tone_step   = val[STEP_W-1:0];
      REG_DEV_STEP:    shadow_cfg.dev_step    = val[STEP_W-1:0];
      default: ; // spare indexes write nothing
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_item(input op_t op, input logic signed [SAMPLE_W-1:0] a_i,
                           input logic signed [SAMPLE_W-1:0] a_q);
    baseband_t res;
    int        gap;
    if (tx_bursty && burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 16);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    burst_left--;
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.in_i      <= a_i;
    in_ch.in_q      <= a_q;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (predict_baseband(op, a_i, a_q, res)) pending_baseband.push_back(res);
  endtask

  // stop offering, wait for every transfer, then let trailing clears finish
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_baseband.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic test_bypass();
    send_item(OP_PROCESS, S_MIN, S_MAX);
    send_item(OP_PROCESS, S_MAX, S_MIN);
    send_item(OP_PROCESS, '0, '0);
    send_item(OP_CLEAR, S_MAX, S_MAX);
    send_item(OP_PROCESS, -16'sd1, 16'sd1);
    wait_drained();
  endtask

  task automatic test_full_deviation();
    write_reg(REG_ENABLE, CFG_DATA_W'(1));
    write_reg(REG_DEV_STEP, '1);
    send_item(OP_CLEAR, '0, '0);
    send_item(OP_PROCESS, S_MAX, '0);
    send_item(OP_PROCESS, S_MIN, '0);
    send_item(OP_PROCESS, '0, S_MIN);
    send_item(OP_PROCESS, 16'sd1, S_MAX);
    wait_drained();
  endtask

  task automatic test_clear();
    // phase is far from zero here, so the clear must bring it back
    send_item(OP_CLEAR, S_MIN, S_MIN);
    send_item(OP_PROCESS, '0, '0);
    wait_drained();
  endtask

  task automatic test_tone_saturation();
    // tone_scale stays at its reset value for the first four samples
    write_reg(REG_TONE_ENABLE, CFG_DATA_W'(1));
    write_reg(REG_TONE_LEVEL, CFG_DATA_W'(15'h7fff));
    write_reg(REG_TONE_STEP, CFG_DATA_W'(32'h4000_0000));
    write_reg(REG_DEV_STEP, CFG_DATA_W'(32'h0100_0000));
    send_item(OP_CLEAR, '0, '0);
    send_item(OP_PROCESS, S_MIN, '0);
    send_item(OP_PROCESS, S_MIN, '0);
    send_item(OP_PROCESS, '0, '0);
    send_item(OP_PROCESS, S_MAX, '0);
    wait_drained();
    write_reg(REG_TONE_SCALE, '0);
    send_item(OP_PROCESS, S_MAX, '0);
    wait_drained();
    write_reg(REG_TONE_SCALE, CFG_DATA_W'(15'h7fff));
    write_reg(REG_TONE_LEVEL, '0);
    send_item(OP_PROCESS, S_MIN, '0);
    wait_drained();
  endtask

  task automatic test_live_reg_write();
    // no clear after the writes: phases carry on from where they were
    write_reg(REG_DEV_STEP, CFG_DATA_W'(32'h0000_1000));
    write_reg(REG_TONE_STEP, '1);
    send_item(OP_PROCESS, 16'sh1234, '0);
    wait_drained();
  endtask

  task automatic test_spare_regs();
    write_reg(REG_SPARE_6, '1);
    write_reg(REG_SPARE_7, '1);
    send_item(OP_PROCESS, -16'sh1234, '0);
    wait_drained();
  endtask

  task automatic test_backpressure();
    int n;
    write_reg(REG_ENABLE, CFG_DATA_W'(1));
    write_reg(REG_TONE_ENABLE, CFG_DATA_W'(1));
    write_reg(REG_TONE_LEVEL, CFG_DATA_W'(15'h0ccd));
    write_reg(REG_TONE_SCALE, CFG_DATA_W'(15'h7459));
    write_reg(REG_TONE_STEP, CFG_DATA_W'(32'h0021_0000));
    write_reg(REG_DEV_STEP, CFG_DATA_W'(32'h0200_0000));
    tx_bursty = 1'b0;
    rx_mode   = RX_STEADY;
    hold_left = LONG_HOLD;
    send_item(OP_CLEAR, '0, '0);
    for (n = 0; n < 15; n++) send_item(OP_PROCESS, pick_sample(), SAMPLE_W'($urandom));
    wait_drained();
    for (n = 0; n < 8; n++) send_item(OP_PROCESS, pick_sample(), SAMPLE_W'($urandom));
    wait_drained();
  endtask

  task automatic random_setup(input int ph);
    logic [CFG_DATA_W-1:0] en, ten, lvl, scl, tstep, dstep;
    longint                ideal;
    en    = {(CFG_DATA_W-1)'($urandom), ($urandom_range(0, 5) != 0)};
    ten   = {(CFG_DATA_W-1)'($urandom), 1'($urandom_range(0, 1))};
    lvl   = {(CFG_DATA_W-LEVEL_W)'($urandom), pick_q15()};
    scl   = {(CFG_DATA_W-LEVEL_W)'($urandom), pick_q15()};
    tstep = pick_step();
    dstep = pick_step();
    if (ph == 0) begin
      en  = CFG_DATA_W'(1);
      ten = CFG_DATA_W'(1);
      lvl = '0;
      scl = '0;
      tstep = '0;
      dstep = '0;
    end else if (ph == 1) begin
      en  = '1;
      ten = '1;
      lvl = '1;
      scl = '1;
      tstep = '1;
      dstep = '1;
    end else if ($urandom_range(0, 2) == 0) begin
      // what software would write: 1/(1+level), saturated
      ideal = (64'sd32768 * 64'sd32768) / (64'sd32768 + longint'(lvl[LEVEL_W-1:0]));
      if (ideal > 32767) ideal = 32767;
      scl = CFG_DATA_W'(ideal);
    end
    write_reg(REG_ENABLE, en);
    write_reg(REG_TONE_ENABLE, ten);
    write_reg(REG_TONE_LEVEL, lvl);
    write_reg(REG_TONE_SCALE, scl);
    write_reg(REG_TONE_STEP, tstep);
    write_reg(REG_DEV_STEP, dstep);
  endtask

  task automatic test_random_sweep();
    int ph, n;
    for (ph = 0; ph < SWEEP_PHASES; ph++) begin
      random_setup(ph);
      tx_bursty = ($urandom_range(0, 3) != 0);
      rx_mode   = rx_mode_t'($urandom_range(0, 2));
      if ($urandom_range(0, 6) != 0) send_item(OP_CLEAR, SAMPLE_W'($urandom), '0);
      for (n = 0; n < SWEEP_ITEMS; n++) begin
        if ($urandom_range(0, 19) == 0)
          send_item(OP_CLEAR, SAMPLE_W'($urandom), SAMPLE_W'($urandom));
        else
          send_item(OP_PROCESS, pick_sample(), SAMPLE_W'($urandom));
      end
      wait_drained();
    end
    tx_bursty = 1'b0;
    rx_mode   = RX_STEADY;
  endtask

  // receiver: stall pattern per mode, with an occasional long hold
  initial begin
    logic [15:0] pattern;
    int          ptr;
    pattern = 16'hffff;
    ptr     = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_PATTERN: begin
            out_ch.ready <= pattern[ptr];
            ptr++;
            if (ptr == 16) begin
              ptr     = 0;
              pattern = 16'($urandom);
            end
          end
          RX_SPARSE: out_ch.ready <= ($urandom_range(0, 3) == 0);
          default:   out_ch.ready <= 1'b1;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    baseband_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_baseband.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected transfer, expected none, actual i=%0d q=%0d",
                 $time, out_ch.out_i, out_ch.out_q);
      end else begin
        want = pending_baseband.pop_front();
        if (out_ch.out_i !== want.re) begin
          n_errors++;
          $display("%0t: out_i mismatch, expected %0d, actual %0d",
                   $time, want.re, out_ch.out_i);
        end
        if (out_ch.out_q !== want.im) begin
          n_errors++;
          $display("%0t: out_q mismatch, expected %0d, actual %0d",
                   $time, want.im, out_ch.out_q);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d results outstanding",
               $time, idle_cycles, pending_baseband.size());
      $display("tb_top failed");
      $finish;
    end
  end

  initial begin
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_addr        <= REG_ENABLE;
    cfg_wdata       <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.operation <= OP_PROCESS;
    in_ch.in_i      <= '0;
    in_ch.in_q      <= '0;
    shadow_cfg             = '0;
    shadow_cfg.tone_scale  = SCALE_RESET;
    tone_phase_acc         = '0;
    mod_phase_acc          = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_bypass();
    test_full_deviation();
    test_clear();
    test_tone_saturation();
    test_live_reg_write();
    test_spare_regs();
    test_backpressure();
    test_random_sweep();
    wait_drained();
    if (n_errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/fmt_pkg.sv
hdl/fmt_in_if.sv
hdl/fmt_out_if.sv
hdl/fmt_front.sv
hdl/fmt_queue.sv
hdl/fmt_sine.sv
hdl/fmt_back.sv
hdl/fm_modulator_with_tone.sv
tb/tb_top.sv
